/* src/arcs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// arcs_pkg
// shared types, codes and helpers of the ascii register command store
// ----------------------------------------------------------------------------
package arcs_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;

   localparam int KEY_W   = 24;
   localparam int VALUE_W = 16;
   localparam int ENTRY_W = KEY_W + VALUE_W;

   localparam logic [3:0] MSG_MAX    = 4'd12;
   localparam logic [3:0] COUNT_OVER = 4'd13;
   localparam logic [3:0] LEN_READ   = 4'd7;
   localparam logic [3:0] LEN_WRITE  = 4'd11;
   localparam logic [3:0] LEN_READ_LF  = 4'd8;
   localparam logic [3:0] LEN_WRITE_LF = 4'd12;

   localparam logic [7:0] LF_BYTE = 8'h0A;
   localparam logic [7:0] CHAR_R  = 8'h52;
   localparam logic [7:0] CHAR_W  = 8'h57;

   typedef enum logic [2:0] {
      ST_ACK        = 3'd0,
      ST_BAD_LENGTH = 3'd1,
      ST_BAD_COMMAND = 3'd2,
      ST_BAD_CHAR   = 3'd3,
      ST_FULL       = 3'd4,
      ST_NOT_FOUND  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_SCAN = 2'd1,
      S_DONE = 2'd2
   } state_type;

   // decoded message, valid in the cycle of the end marker
   typedef struct packed {
      status_type         status;
      logic               is_write;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } msg_info_type;

   function automatic logic is_hex(input logic [7:0] c);
      logic r;
      r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
          ((c >= 8'h41) && (c <= 8'h46));
      return r;
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] r;
      if ((c >= 8'h30) && (c <= 8'h39)) begin
         r = c - 8'h30;
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         r = c - 8'h57;
      end else begin
         r = c - 8'h37;
      end
      return r[3:0];
   endfunction

endpackage
`default_nettype wire

/* src/arcs_table_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// arcs_table_ram
// key/value table, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module arcs_table_ram import arcs_pkg::*; #(
   parameter int DEPTH = TABLE_DEPTH_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire logic [ENTRY_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      rd_addr,
   output logic      [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* src/arcs_msg_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// arcs_msg_parser
// collects message beats, parses hex fields on the fly, checks at end marker
// ----------------------------------------------------------------------------
module arcs_msg_parser import arcs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_en,
   input  wire logic       end_en,
   input  wire logic [7:0] data_byte,
   output msg_info_type    info
);

   logic [3:0]         count_ff, count_in;
   logic [7:0]         cmd_ff, cmd_in;
   logic               lo_ok_ff, lo_ok_in;
   logic               hi_ok_ff, hi_ok_in;
   logic               last_lf_ff, last_lf_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [3:0]         nib;
   logic               hex;
   logic [3:0]         len;

   assign nib = hex_nibble(data_byte);
   assign hex = is_hex(data_byte);

   always_comb begin
      count_in   = count_ff;
      cmd_in     = cmd_ff;
      lo_ok_in   = lo_ok_ff;
      hi_ok_in   = hi_ok_ff;
      last_lf_in = last_lf_ff;
      key_in     = key_ff;
      value_in   = value_ff;
      if (byte_en) begin
         if (count_ff < COUNT_OVER) begin
            count_in = count_ff + 4'd1;
         end
         if (count_ff < MSG_MAX) begin
            last_lf_in = (data_byte == LF_BYTE);
         end
         case (count_ff) inside
            4'd0: begin
               cmd_in   = data_byte;
               lo_ok_in = 1'b1;
               hi_ok_in = 1'b1;
            end
            [4'd1:4'd6]: begin
               key_in   = {key_ff[KEY_W-5:0], nib};
               lo_ok_in = lo_ok_ff & hex;
            end
            [4'd7:4'd10]: begin
               value_in = {value_ff[VALUE_W-5:0], nib};
               hi_ok_in = hi_ok_ff & hex;
            end
            default: begin
            end
         endcase
      end else if (end_en) begin
         count_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      lo_ok_ff   <= lo_ok_in;
      hi_ok_ff   <= hi_ok_in;
      last_lf_ff <= last_lf_in;
      key_ff     <= key_in;
      value_ff   <= value_in;
   end

   // length check, lf strip, command and character checks
   always_comb begin
      len           = count_ff;
      info.is_write = (cmd_ff == CHAR_W);
      info.key      = key_ff;
      info.value    = value_ff;
      if ((count_ff == 4'd0) || (count_ff > MSG_MAX)) begin
         info.status = ST_BAD_LENGTH;
      end else if (((count_ff == LEN_READ_LF) || (count_ff == LEN_WRITE_LF)) &&
                   !last_lf_ff) begin
         info.status = ST_BAD_LENGTH;
      end else begin
         if ((count_ff == LEN_READ_LF) || (count_ff == LEN_WRITE_LF)) begin
            len = count_ff - 4'd1;
         end
         if (!(((len == LEN_READ) && (cmd_ff == CHAR_R)) ||
               ((len == LEN_WRITE) && (cmd_ff == CHAR_W)))) begin
            info.status = ST_BAD_COMMAND;
         end else if (!(lo_ok_ff && ((cmd_ff != CHAR_W) || hi_ok_ff))) begin
            info.status = ST_BAD_CHAR;
         end else begin
            info.status = ST_ACK;
         end
      end
   end

endmodule
`default_nettype wire

/* src/ascii_register_command_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_register_command_store
// ascii read/write command parser in front of a bounded key/value table
// ----------------------------------------------------------------------------
// message beats: busy stays low, no result
// end marker with a format error: result strobed on the next cycle
// end marker of a valid command: table scan of one entry per cycle through the
//   ram read port; busy until the key matches or every stored entry is compared
//   (not at all scanned when the table is empty); result strobed in the first idle cycle
// synchronous reset empties the table (fill count to zero) and the byte count
module ascii_register_command_store import arcs_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_device_id,
   output logic [7:0]       rsp_register_id,
   output logic [15:0]      rsp_reg_value,
   output logic [6:0]       rsp_entry_count
);

   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int EXT_W = CW + 7;

   // beat acceptance
   logic accept, byte_en, end_en;
   msg_info_type info;

   state_type state_ff, state_in;

   // fill count: entries below it are valid, slots fill in order
   logic [CW-1:0] stored_ff, stored_in;

   // scan pipeline: issue index, then compare in the following cycle
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;

   // lookup outcome
   logic               hit_ff, hit_in;
   logic [AW-1:0]      hit_idx_ff, hit_idx_in;
   logic [VALUE_W-1:0] hit_val_ff, hit_val_in;

   // command under way
   logic               is_write_ff, is_write_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] val_ff, val_in;

   // response
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [6:0]         rsp_count_ff, rsp_count_in;

   // ram ports
   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [ENTRY_W-1:0] rd_data, wr_data;

   logic [EXT_W-1:0] stored_ext;
   logic             match;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign byte_en = accept && !req_kind;
   assign end_en  = accept && req_kind;

   assign stored_ext = EXT_W'(stored_ff);
   assign match      = cmp_valid_ff && (rd_data[ENTRY_W-1:VALUE_W] == key_ff);

   arcs_msg_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (byte_en),
      .end_en    (end_en),
      .data_byte (req_data_byte),
      .info      (info)
   );

   arcs_table_ram #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      stored_in     = stored_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_val_in    = hit_val_ff;
      is_write_in   = is_write_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_idx_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = hit_idx_ff;
      wr_data       = {key_ff, val_ff};

      case (state_ff)
         S_IDLE: begin
            if (end_en) begin
               if (info.status != ST_ACK) begin
                  // format error, answered at once with zero fields
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = info.status;
                  rsp_key_in    = '0;
                  rsp_value_in  = '0;
                  rsp_count_in  = '0;
               end else begin
                  is_write_in  = info.is_write;
                  key_in       = info.key;
                  val_in       = info.value;
                  scan_idx_in  = '0;
                  cmp_valid_in = 1'b0;
                  hit_in       = 1'b0;
                  state_in     = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (match) begin
               hit_in       = 1'b1;
               hit_idx_in   = cmp_idx_ff;
               hit_val_in   = rd_data[VALUE_W-1:0];
               cmp_valid_in = 1'b0;
               state_in     = S_DONE;
            end else if (scan_idx_ff < stored_ff) begin
               rd_en        = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_idx_ff[AW-1:0];
               scan_idx_in  = scan_idx_ff + CW'(1);
            end else if (!cmp_valid_ff) begin
               // every valid entry compared, key absent
               state_in = S_DONE;
            end else begin
               cmp_valid_in = 1'b0;
            end
         end

         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_count_in = '0;
            state_in     = S_IDLE;
            if (is_write_ff) begin
               if (hit_ff) begin
                  wr_en         = 1'b1;
                  wr_addr       = hit_idx_ff;
                  rsp_status_in = ST_ACK;
                  rsp_key_in    = key_ff;
                  rsp_value_in  = val_ff;
               end else if (stored_ff >= CW'(TABLE_DEPTH)) begin
                  rsp_status_in = ST_FULL;
                  rsp_key_in    = '0;
                  rsp_value_in  = '0;
                  rsp_count_in  = stored_ext[6:0];
               end else begin
                  // new entry goes to the next free slot
                  wr_en         = 1'b1;
                  wr_addr       = stored_ff[AW-1:0];
                  stored_in     = stored_ff + CW'(1);
                  rsp_status_in = ST_ACK;
                  rsp_key_in    = key_ff;
                  rsp_value_in  = val_ff;
               end
            end else if (hit_ff) begin
               rsp_status_in = ST_ACK;
               rsp_key_in    = key_ff;
               rsp_value_in  = hit_val_ff;
            end else begin
               rsp_status_in = ST_NOT_FOUND;
               rsp_key_in    = '0;
               rsp_value_in  = '0;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stored_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stored_ff    <= stored_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_val_ff    <= hit_val_in;
      is_write_ff   <= is_write_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_device_id   = rsp_key_ff[KEY_W-1:8];
   assign rsp_register_id = rsp_key_ff[7:0];
   assign rsp_reg_value   = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

   // fill count never passes the table depth
   a_stored_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= CW'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   // the fill count moves only with a write ack
   a_stored_step: assert property (@(posedge clock) disable iff (reset)
      (stored_ff != $past(stored_ff)) |->
         (rsp_valid_ff && (rsp_status_ff == ST_ACK) && (stored_ff == $past(stored_ff) + CW'(1))))
      else $error("fill count changed without a new entry");

   // a result follows only an end marker or a finished lookup
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(end_en) || ($past(state_ff) == S_DONE)))
      else $error("result without a cause");

   // scan never reads past the valid entries
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (scan_idx_ff < stored_ff))
      else $error("scan read of an unwritten entry");

   // non-ack results carry zero id and value fields
   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_ACK)) |->
         ((rsp_key_ff == '0) && (rsp_value_ff == '0)))
      else $error("error result with nonzero fields");

endmodule
`default_nettype wire

/* test/ascii_register_command_store_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_register_command_store_tb
// drives ascii read/write messages beat by beat through the start/busy port,
// predicts every status answer from its own copy of the message buffer and
// key/value store, and checks each strobed answer field by field
// ----------------------------------------------------------------------------
module ascii_register_command_store_tb import arcs_pkg::*;;

   // store geometry and message framing
   localparam int STORE_DEPTH  = TABLE_DEPTH_DEFAULT;
   localparam int MAX_BYTES    = 12;
   localparam int SAT_BYTES    = 13;
   localparam int READ_LEN     = 7;
   localparam int WRITE_LEN    = 11;
   localparam int READ_LF_LEN  = 8;
   localparam int WRITE_LF_LEN = 12;

   // run shaping
   localparam int IDLE_PCT      = 22;
   localparam int RANDOM_BEATS  = 1300;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DIRECTED_ROWS = 24;

   // one answer of the block, in port order
   typedef struct packed {
      status_type  status;
      logic [15:0] dev_id;
      logic [7:0]  reg_id;
      logic [15:0] value;
      logic [6:0]  fill;
   } store_answer_type;

   logic        clock;
   logic        reset         = 1'b1;
   logic        start         = 1'b0;
   logic        req_kind      = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        busy;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_device_id;
   logic [7:0]  rsp_register_id;
   logic [15:0] rsp_reg_value;
   logic [6:0]  rsp_entry_count;

   ascii_register_command_store #(
      .TABLE_DEPTH(STORE_DEPTH)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_device_id  (rsp_device_id),
      .rsp_register_id(rsp_register_id),
      .rsp_reg_value  (rsp_reg_value),
      .rsp_entry_count(rsp_entry_count)
   );

   // ---------------------------------------------------------------------------
   // predictor state: current message and the key/value store
   // ---------------------------------------------------------------------------
   logic [7:0]    msg_bytes [MAX_BYTES];
   int            msg_len;
   logic [23:0]   store_keys [STORE_DEPTH];
   logic [15:0]   store_values [STORE_DEPTH];
   int            store_fill;

   store_answer_type pending_answers [$];   // answers owed by the block, oldest first
   logic [7:0]    draft [$];             // message under construction
   int            mismatches;
   int            beats_sent;
   int            cycle_count;
   bit            calm_stretch;          // no gaps on the sender side

   // ---------------------------------------------------------------------------
   // directed table: one message per row, answer typed in where obvious
   // ---------------------------------------------------------------------------
   string directed_text [DIRECTED_ROWS] = '{
      "",                       // empty message
      "R123456",                // read on an empty store
      "W0000000000",            // all-zero write
      "WFFFFFFFFFF\n",          // all-ones write, trailing lf stripped
      "RFFFFFF\n",              // read back with trailing lf
      "Wabcdef0123",            // lower case digits
      "RaBcDeF",                // mixed case lookup of the same key
      "W000000BEEF\n",          // update of an existing key
      "R000000",                // read the updated value
      "R1234567",               // eight bytes without lf
      "W123456789AB",           // twelve bytes without lf
      "R0000000000000000",      // overlong, count saturates
      "X123456",                // unknown command letter
      "r123456",                // command letter is case sensitive
      "R12345",                 // read one digit short
      "W123456",                // write with read length
      "\n",                     // lone lf
      "W12345678\n",            // ten bytes
      "R/00000",                // just below '0'
      "R00:000",                // just above '9'
      "RA@0000",                // just below 'A'
      "R0000G0",                // just above 'F'
      "R\14000000",             // backtick, just below 'a'
      "W0000000g00"             // just above 'f'
   };

   bit directed_typed [DIRECTED_ROWS] = '{
      1, 1, 1, 1, 1, 1, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1
   };

   store_answer_type directed_answer [DIRECTED_ROWS] = '{
      '{ST_BAD_LENGTH,  16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_NOT_FOUND,   16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_ACK,         16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_ACK,         16'hFFFF, 8'hFF, 16'hFFFF, 7'd0},
      '{ST_ACK,         16'hFFFF, 8'hFF, 16'hFFFF, 7'd0},
      '{ST_ACK,         16'hABCD, 8'hEF, 16'h0123, 7'd0},
      '{ST_ACK,         16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_ACK,         16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_ACK,         16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_LENGTH,  16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_LENGTH,  16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_LENGTH,  16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_COMMAND, 16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_COMMAND, 16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_COMMAND, 16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_COMMAND, 16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_COMMAND, 16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_COMMAND, 16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_CHAR,    16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_CHAR,    16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_CHAR,    16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_CHAR,    16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_CHAR,    16'h0000, 8'h00, 16'h0000, 7'd0},
      '{ST_BAD_CHAR,    16'h0000, 8'h00, 16'h0000, 7'd0}
   };

   // ---------------------------------------------------------------------------
   // clock
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // {is hex digit, nibble} of one character
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      logic [7:0] t;
      if (c >= "0" && c <= "9") begin
         t = c - "0";
         return {1'b1, t[3:0]};
      end
      if (c >= "a" && c <= "f") begin
         t = c - "a" + 8'd10;
         return {1'b1, t[3:0]};
      end
      if (c >= "A" && c <= "F") begin
         t = c - "A" + 8'd10;
         return {1'b1, t[3:0]};
      end
      return 5'b0_0000;
   endfunction

   // message beat: bytes past the twelfth are dropped, the count sticks at 13
   function automatic void take_byte(input logic [7:0] data);
      if (msg_len < MAX_BYTES) begin
         msg_bytes[msg_len] = data;
      end
      if (msg_len < SAT_BYTES) begin
         msg_len++;
      end
   endfunction

   // end marker: validate, then run the read or write against the store
   function automatic store_answer_type close_message();
      store_answer_type ans;
      int            len;
      int            slot;
      logic [7:0]    cmd;
      logic [4:0]    nib;
      logic [39:0]   digits;
      logic [23:0]   key;
      logic [15:0]   val;
      ans        = '0;
      ans.status = ST_ACK;
      len        = msg_len;
      msg_len    = 0;
      digits     = '0;
      if (len == 0 || len > MAX_BYTES) begin
         ans.status = ST_BAD_LENGTH;
         return ans;
      end
      // lengths 8 and 12 carry a trailing lf that is stripped
      if (len == READ_LF_LEN || len == WRITE_LF_LEN) begin
         if (msg_bytes[len-1] != LF_BYTE) begin
            ans.status = ST_BAD_LENGTH;
            return ans;
         end
         len--;
      end
      cmd = msg_bytes[0];
      if (!((len == READ_LEN && cmd == CHAR_R) || (len == WRITE_LEN && cmd == CHAR_W))) begin
         ans.status = ST_BAD_COMMAND;
         return ans;
      end
      for (int i = 1; i < len; i++) begin
         nib = nibble_of(msg_bytes[i]);
         if (!nib[4]) begin
            ans.status = ST_BAD_CHAR;
            return ans;
         end
         digits = {digits[35:0], nib[3:0]};
      end
      key  = (cmd == CHAR_W) ? digits[39:16] : digits[23:0];
      val  = digits[15:0];
      slot = -1;
      for (int i = 0; i < store_fill; i++) begin
         if (slot < 0 && store_keys[i] == key) begin
            slot = i;
         end
      end
      if (cmd == CHAR_W) begin
         if (slot < 0) begin
            if (store_fill >= STORE_DEPTH) begin
               ans.status = ST_FULL;
               ans.fill   = 7'(store_fill);
               return ans;
            end
            slot       = store_fill;
            store_keys[slot] = key;
            store_fill++;
         end
         store_values[slot] = val;
      end else begin
         if (slot < 0) begin
            ans.status = ST_NOT_FOUND;
            return ans;
         end
         val = store_values[slot];
      end
      ans.dev_id = key[23:8];
      ans.reg_id = key[7:0];
      ans.value  = val;
      return ans;
   endfunction

   // ---------------------------------------------------------------------------
   // message building
   // ---------------------------------------------------------------------------
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return "0" + 8'(n);
      end
      // either case is legal
      return ($urandom_range(1) != 0) ? ("a" + 8'(n) - 8'd10) : ("A" + 8'(n) - 8'd10);
   endfunction

   function automatic void push_hex(input logic [39:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) begin
         draft.push_back(hex_char(v[4*i +: 4]));
      end
   endfunction

   // mostly fresh keys while the store fills, otherwise reuse stored ones
   function automatic logic [23:0] pick_key(input int fresh_pct);
      if (store_fill == 0 || $urandom_range(99) < fresh_pct) begin
         return 24'($urandom);
      end
      return store_keys[$urandom_range(store_fill - 1)];
   endfunction

   function automatic void build_command(input bit is_write, input bit with_lf);
      logic [23:0] key;
      int          fresh_pct;
      // writes fill the store quickly, then mix updates with overflow attempts
      fresh_pct = !is_write ? 30 : (store_fill < STORE_DEPTH) ? 100 : 50;
      key       = pick_key(fresh_pct);
      draft.delete();
      draft.push_back(is_write ? CHAR_W : CHAR_R);
      if (is_write) begin
         push_hex({key, 16'($urandom)}, 10);
      end else begin
         push_hex({16'h0000, key}, 6);
      end
      if (with_lf) begin
         draft.push_back(LF_BYTE);
      end
   endfunction

   // noise and near misses of a well-formed command
   function automatic void build_broken();
      int         n;
      int         pos;
      logic [7:0] b;
      build_command(1'($urandom_range(1)), 1'($urandom_range(1)));
      case ($urandom_range(5))
         0: begin
            // random bytes, half of them hex digits
            draft.delete();
            n = $urandom_range(15);
            repeat (n) begin
               draft.push_back(($urandom_range(1) != 0) ? hex_char(4'($urandom)) : 8'($urandom));
            end
         end
         1: begin
            pos        = $urandom_range(draft.size() - 1, 1);
            draft[pos] = 8'($urandom);
         end
         2: begin
            draft[0] = 8'($urandom);
         end
         3: begin
            // lf slot filled with something else
            build_command(1'($urandom_range(1)), 1'b0);
            b = 8'($urandom);
            if (b == LF_BYTE) begin
               b = ~b;
            end
            draft.push_back(b);
         end
         4: begin
            n = $urandom_range(4, 1);
            repeat (n) draft.push_back(8'($urandom));
         end
         default: begin
            void'(draft.pop_back());
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------------

   // present one beat at the falling edge and hold it until start && !busy
   task automatic send_beat(input logic kind, input logic [7:0] data,
                            input bit has_given, input store_answer_type given);
      store_answer_type ans;
      @(negedge clock);
      while (!calm_stretch && $urandom_range(99) < IDLE_PCT) begin
         start         <= 1'b0;
         req_kind      <= 1'($urandom);
         req_data_byte <= 8'($urandom);
         @(negedge clock);
      end
      start         <= 1'b1;
      req_kind      <= kind;
      req_data_byte <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
      if (kind == 1'b0) begin
         take_byte(data);
      end else begin
         ans = close_message();
         if (has_given) begin
            ans = given;
         end
         pending_answers.push_back(ans);
      end
   endtask

   // the draft's bytes, then the end marker with a junk data byte
   task automatic send_message(input bit has_given, input store_answer_type given);
      foreach (draft[i]) begin
         send_beat(1'b0, draft[i], 1'b0, '0);
      end
      send_beat(1'b1, 8'($urandom), has_given, given);
   endtask

   // ---------------------------------------------------------------------------
   // answer checking
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // each strobe is one answer, taken at the edge that ends its cycle
   always @(posedge clock) begin
      store_answer_type exp;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("answer with status %0d but none owed", rsp_status));
         end else begin
            exp = pending_answers.pop_front();
            if (rsp_status !== exp.status) begin
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, exp.status));
            end
            if (rsp_device_id !== exp.dev_id) begin
               report_mismatch($sformatf("device_id %h, want %h", rsp_device_id, exp.dev_id));
            end
            if (rsp_register_id !== exp.reg_id) begin
               report_mismatch($sformatf("register_id %h, want %h",
                                         rsp_register_id, exp.reg_id));
            end
            if (rsp_reg_value !== exp.value) begin
               report_mismatch($sformatf("reg_value %h, want %h", rsp_reg_value, exp.value));
            end
            if (rsp_entry_count !== exp.fill) begin
               report_mismatch($sformatf("entry_count %0d, want %0d",
                                         rsp_entry_count, exp.fill));
            end
         end
      end
   end

   // hang guard, far above the slowest legal run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ascii_register_command_store_tb: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int pick;
      msg_len      = 0;
      store_fill   = 0;
      mismatches   = 0;
      beats_sent   = 0;
      calm_stretch = 1'b0;

      // synchronous reset, released on a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed messages
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         draft.delete();
         for (int i = 0; i < directed_text[row].len(); i++) begin
            draft.push_back(directed_text[row][i]);
         end
         send_message(directed_typed[row], directed_answer[row]);
      end

      // random messages: mostly writes, so the store fills and overflows
      while (beats_sent < RANDOM_BEATS) begin
         calm_stretch = (beats_sent >= 400 && beats_sent < 700);
         pick = $urandom_range(99);
         if (pick < 75) begin
            build_command(1'b1, 1'($urandom_range(1)));
         end else if (pick < 88) begin
            build_command(1'b0, 1'($urandom_range(1)));
         end else begin
            build_broken();
         end
         send_message(1'b0, '0);
      end

      // release start once the last beat is taken, then drain
      @(negedge clock);
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      // a full table scan plus margin for any stray answer
      repeat (STORE_DEPTH + 16) @(posedge clock);

      if (mismatches == 0) begin
         $display("ascii_register_command_store_tb: PASS");
      end else begin
         $display("ascii_register_command_store_tb: FAIL");
      end
      $finish;
   end

endmodule
